/* rtl/core/bog_pkg.sv */
// Shared types, constants and helper functions of the block occupancy grid.
package bog_pkg;

  localparam int DIM_BITS = 12;
  localparam int GRID_COLUMNS_DEF = 16;

  localparam int SIZE_W = 13;
  localparam int PCT_W = 7;
  localparam int TOP_W = 6;
  localparam int PIX_W = 8;
  localparam int SUM_W = 32;
  localparam int LEVEL_W = 9;
  localparam int AREA_W = 2 * DIM_BITS + 1;
  localparam int PROD_W = LEVEL_W + AREA_W;
  localparam int ROW_W = 13;
  localparam int COL_W = 12;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_PERCENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_ROW = 3'd5;

  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH = 13'd640;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [SIZE_W-1:0] RST_BLOCK_WIDTH = 13'd40;
  localparam logic [SIZE_W-1:0] RST_BLOCK_HEIGHT = 13'd30;
  localparam logic [PCT_W-1:0] RST_OCC_PERCENT = 7'd50;
  localparam logic [TOP_W-1:0] RST_TOP_ROW = 6'd15;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(1 << DIM_BITS);
  localparam logic [14:0] FULL_WHITE = 15'd255;
  localparam logic [30:0] RECIP_100 = 31'd41944;
  localparam int RECIP_SHIFT = 22;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic signed [ROW_W-1:0] grid_row;
    logic [COL_W-1:0]        grid_col;
    logic                    occupied;
    logic                    out_of_grid;
    logic                    last_of_frame;
  } out_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] width_m1;
    logic [DIM_BITS-1:0] height_m1;
    logic [DIM_BITS-1:0] bw_m1;
    logic [DIM_BITS-1:0] bh_m1;
    logic [LEVEL_W-1:0]  level;
    logic [TOP_W-1:0]    top_row;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic load_area;
    logic load_prod;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tile_end;
  } ctrl_sts_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_MAX) begin
      r = SIZE_MAX;
    end
    return r;
  endfunction

  // floor(255 * p / 100) by reciprocal multiply, exact for any 7-bit p
  function automatic logic [LEVEL_W-1:0] occupancy_level(input logic [PCT_W-1:0] p);
    logic [14:0] x;
    logic [30:0] m;
    x = 15'({8'b0, p} * FULL_WHITE);
    m = 31'(x) * RECIP_100;
    return m[RECIP_SHIFT +: LEVEL_W];
  endfunction

endpackage

/* rtl/core/block_occupancy_grid.sv */
// Top level of the block occupancy grid: registers, controller and datapath.
//
// Input channel in_valid/in_stall/in_data carries one mask pixel per word in
// raster order; frame_start on a word restarts the position at the image origin.
// The image is cut into block_width by block_height tiles, clipped at the right
// and bottom edges. When a tile's last pixel is taken, one result word leaves on
// out_valid/out_stall/out_data with the tile's grid row and column, whether its
// mean exceeds the occupancy level, an out-of-grid flag and a last-of-frame flag.
// Pixels that do not close a tile are taken without holding the input. After a
// tile-closing pixel, in_stall stays high while the area and the level-times-area
// product go through two registered multiplies and the compare loads the output
// register once it is free; the result then appears on out_valid.
// While out_stall holds a result, the next pixels are still taken until another
// tile closes; that tile then waits in the compare step and in_stall stays high.
// Reset restores the register defaults (640x480 image, 40x30 tiles, 50 percent,
// top row 15), zeroes the position and tile sums, and empties the output. The user
// must write configuration through the cfg_ port while no word is in flight; not enforced.
module block_occupancy_grid #(
  parameter int GRID_COLUMNS = bog_pkg::GRID_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bog_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bog_pkg::out_t                  out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bog_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bog_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bog_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import bog_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;

  bog_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bog_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bog_datapath #(
    .GRID_COLUMNS (GRID_COLUMNS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* rtl/core/bog_regs.sv */
// Configuration register file of the block occupancy grid, APB-style access.
module bog_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bog_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bog_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bog_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output bog_pkg::cfg_t                  cfg
);
  import bog_pkg::*;

  logic [SIZE_W-1:0]    iw_r, ih_r, bw_r, bh_r;
  logic [PCT_W-1:0]     pct_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [TOP_W-1:0]     top_r;
  logic [CFG_IDX_W-1:0] idx;
  logic                 wr_en;
  logic [SIZE_W-1:0]    size_in;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign size_in = clamp_size(cfg_pwdata[SIZE_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r    <= RST_IMAGE_WIDTH;
      ih_r    <= RST_IMAGE_HEIGHT;
      bw_r    <= RST_BLOCK_WIDTH;
      bh_r    <= RST_BLOCK_HEIGHT;
      pct_r   <= RST_OCC_PERCENT;
      level_r <= occupancy_level(RST_OCC_PERCENT);
      top_r   <= RST_TOP_ROW;
    end else if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  iw_r <= size_in;
        REG_IMAGE_HEIGHT: ih_r <= size_in;
        REG_BLOCK_WIDTH:  bw_r <= size_in;
        REG_BLOCK_HEIGHT: bh_r <= size_in;
        REG_OCC_PERCENT: begin
          pct_r   <= cfg_pwdata[PCT_W-1:0];
          level_r <= occupancy_level(cfg_pwdata[PCT_W-1:0]);
        end
        REG_TOP_ROW:      top_r <= cfg_pwdata[TOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DATA_W'(iw_r);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DATA_W'(ih_r);
      REG_BLOCK_WIDTH:  cfg_prdata = CFG_DATA_W'(bw_r);
      REG_BLOCK_HEIGHT: cfg_prdata = CFG_DATA_W'(bh_r);
      REG_OCC_PERCENT:  cfg_prdata = CFG_DATA_W'(pct_r);
      REG_TOP_ROW:      cfg_prdata = CFG_DATA_W'(top_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.width_m1  = DIM_BITS'(iw_r - SIZE_W'(1));
    cfg.height_m1 = DIM_BITS'(ih_r - SIZE_W'(1));
    cfg.bw_m1     = DIM_BITS'(bw_r - SIZE_W'(1));
    cfg.bh_m1     = DIM_BITS'(bh_r - SIZE_W'(1));
    cfg.level     = level_r;
    cfg.top_row   = top_r;
  end

endmodule

/* rtl/core/bog_ctrl.sv */
// Controller state machine of the block occupancy grid: accept, multiply, emit.
module bog_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bog_pkg::ctrl_sts_t  sts,
  output bog_pkg::ctrl_cmd_t  cmd
);
  import bog_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_AREA = 2'd1;
  localparam logic [1:0] S_PROD = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept    = in_valid & (state_r == S_IDLE);
    cmd.load_area = (state_r == S_AREA);
    cmd.load_prod = (state_r == S_PROD);
    cmd.load_out  = (state_r == S_EMIT) & (!out_valid_r | !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.accept && sts.tile_end) state_nxt = S_AREA;
      S_AREA: state_nxt = S_PROD;
      S_PROD: state_nxt = S_EMIT;
      S_EMIT: if (cmd.load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_tile_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && sts.tile_end |=> state_r == S_AREA)
    else $error("tile end did not start the threshold sequence");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_valid_r && out_stall |=> state_r == S_EMIT && out_valid_r)
    else $error("result left while the output word was still pending");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("pending output word overwritten");

  a_prod_after_area: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_area |=> cmd.load_prod)
    else $error("product step skipped");

endmodule

/* rtl/core/bog_datapath.sv */
// Datapath of the block occupancy grid: position counters, tile sums, threshold compare.
module bog_datapath #(
  parameter int GRID_COLUMNS = bog_pkg::GRID_COLUMNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bog_pkg::in_t        in_data,
  input  bog_pkg::cfg_t       cfg,
  input  bog_pkg::ctrl_cmd_t  cmd,
  output bog_pkg::ctrl_sts_t  sts,
  output bog_pkg::out_t       out_data
);
  import bog_pkg::*;

  localparam int IDX_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;

  logic [DIM_BITS-1:0] pc_r, pr_r, cit_r, rit_r, tc_r, tr_r;
  logic [DIM_BITS-1:0] pc_nxt, pr_nxt, cit_nxt, rit_nxt, tc_nxt, tr_nxt;
  logic [DIM_BITS-1:0] e_pc, e_pr, e_cit, e_rit, e_tc, e_tr;
  logic [SUM_W-1:0]    sums_r [GRID_COLUMNS];
  logic [SUM_W-1:0]    sum_new;
  logic [IDX_W-1:0]    idx;
  logic                line_end, col_end, last_line, row_end, in_grid, tile_start;

  logic [SUM_W-1:0]    sum_r;
  logic [DIM_BITS-1:0] cit_cap_r, rit_cap_r, col_r;
  logic [ROW_W-1:0]    grow_r, grow_nxt;
  logic                in_grid_r, last_r;
  logic [AREA_W-1:0]   area_r;
  logic [PROD_W-1:0]   prod_r;
  out_t                out_r;
  logic [DIM_BITS:0]   w_cnt, h_cnt;

  always_comb begin
    e_pc  = in_data.frame_start ? '0 : pc_r;
    e_pr  = in_data.frame_start ? '0 : pr_r;
    e_cit = in_data.frame_start ? '0 : cit_r;
    e_rit = in_data.frame_start ? '0 : rit_r;
    e_tc  = in_data.frame_start ? '0 : tc_r;
    e_tr  = in_data.frame_start ? '0 : tr_r;
  end

  assign line_end   = e_pc >= cfg.width_m1;
  assign col_end    = line_end | (e_cit >= cfg.bw_m1);
  assign last_line  = e_pr >= cfg.height_m1;
  assign row_end    = last_line | (e_rit >= cfg.bh_m1);
  assign in_grid    = e_tc < DIM_BITS'(GRID_COLUMNS);
  assign tile_start = (e_cit == '0) && (e_rit == '0);
  assign idx        = e_tc[IDX_W-1:0];
  assign sum_new    = tile_start ? SUM_W'(in_data.pixel)
                                 : sums_r[idx] + SUM_W'(in_data.pixel);
  assign grow_nxt   = ROW_W'(cfg.top_row) - ROW_W'(e_tr);
  assign sts.tile_end = col_end & row_end;

  always_comb begin
    pc_nxt  = e_pc + DIM_BITS'(1);
    pr_nxt  = e_pr;
    cit_nxt = e_cit;
    rit_nxt = e_rit;
    tc_nxt  = e_tc;
    tr_nxt  = e_tr;
    if (line_end) begin
      pc_nxt  = '0;
      cit_nxt = '0;
      tc_nxt  = '0;
      if (last_line) begin
        pr_nxt  = '0;
        rit_nxt = '0;
        tr_nxt  = '0;
      end else begin
        pr_nxt = e_pr + DIM_BITS'(1);
        if (row_end) begin
          rit_nxt = '0;
          tr_nxt  = e_tr + DIM_BITS'(1);
        end else begin
          rit_nxt = e_rit + DIM_BITS'(1);
        end
      end
    end else if (col_end) begin
      cit_nxt = '0;
      tc_nxt  = e_tc + DIM_BITS'(1);
    end else begin
      cit_nxt = e_cit + DIM_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      pr_r  <= '0;
      cit_r <= '0;
      rit_r <= '0;
      tc_r  <= '0;
      tr_r  <= '0;
      for (int i = 0; i < GRID_COLUMNS; i++) begin
        sums_r[i] <= '0;
      end
    end else if (cmd.accept) begin
      pc_r  <= pc_nxt;
      pr_r  <= pr_nxt;
      cit_r <= cit_nxt;
      rit_r <= rit_nxt;
      tc_r  <= tc_nxt;
      tr_r  <= tr_nxt;
      if (in_grid) begin
        sums_r[idx] <= sum_new;
      end
    end
  end

  assign w_cnt = (DIM_BITS + 1)'(cit_cap_r) + (DIM_BITS + 1)'(1);
  assign h_cnt = (DIM_BITS + 1)'(rit_cap_r) + (DIM_BITS + 1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_r     <= sum_new;
      cit_cap_r <= e_cit;
      rit_cap_r <= e_rit;
      col_r     <= e_tc;
      grow_r    <= grow_nxt;
      in_grid_r <= in_grid;
      last_r    <= line_end & last_line;
    end
    if (cmd.load_area) begin
      area_r <= AREA_W'(w_cnt * h_cnt);
    end
    if (cmd.load_prod) begin
      prod_r <= PROD_W'(cfg.level) * PROD_W'(area_r);
    end
    if (cmd.load_out) begin
      out_r.grid_row      <= $signed(grow_r);
      out_r.grid_col      <= COL_W'(col_r);
      out_r.occupied      <= in_grid_r & (PROD_W'(sum_r) > prod_r);
      out_r.out_of_grid   <= grow_r[ROW_W-1] | !in_grid_r;
      out_r.last_of_frame <= last_r;
    end
  end

  assign out_data = out_r;

endmodule

/* bench/block_occupancy_grid_test.sv */
// Self-checking testbench for the block occupancy grid: predicts each tile result.
module block_occupancy_grid_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bog_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int REPORT_CAP = 50;

  typedef enum {PIX_ANY, PIX_EXTREME, PIX_NEAR_LEVEL} pixel_mode_t;

  class tile_scoreboard_t;
    int unsigned img_w, img_h, blk_w, blk_h, pct, top;
    logic [DIM_BITS-1:0] col_pos, row_pos, col_in, row_in, tcol, trow;
    logic [SUM_W-1:0] sums [GRID_COLUMNS_DEF];
    out_t tile_queue [$];
    int failures;

    function new();
      img_w = RST_IMAGE_WIDTH;
      img_h = RST_IMAGE_HEIGHT;
      blk_w = RST_BLOCK_WIDTH;
      blk_h = RST_BLOCK_HEIGHT;
      pct = RST_OCC_PERCENT;
      top = RST_TOP_ROW;
      home();
      foreach (sums[i]) sums[i] = '0;
      failures = 0;
    endfunction

    function void home();
      col_pos = '0;
      row_pos = '0;
      col_in = '0;
      row_in = '0;
      tcol = '0;
      trow = '0;
    endfunction

    function int unsigned size_of(logic [31:0] v);
      int unsigned s;
      s = v[SIZE_W-1:0];
      if (s == 0) s = 1;
      if (s > (1 << DIM_BITS)) s = 1 << DIM_BITS;
      return s;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_IMAGE_WIDTH: img_w = size_of(v);
        REG_IMAGE_HEIGHT: img_h = size_of(v);
        REG_BLOCK_WIDTH: blk_w = size_of(v);
        REG_BLOCK_HEIGHT: blk_h = size_of(v);
        REG_OCC_PERCENT: pct = v[PCT_W-1:0];
        REG_TOP_ROW: top = v[TOP_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return tile_queue.size();
    endfunction

    function void note_pixel(in_t w);
      bit in_col, line_end, col_end, last_line, row_end;
      int grow;
      logic [63:0] area, bound;
      out_t t;
      if (w.frame_start) home();
      in_col = tcol < GRID_COLUMNS_DEF;
      if (in_col) begin
        if (col_in == 0 && row_in == 0) sums[tcol] = {24'b0, w.pixel};
        else sums[tcol] = sums[tcol] + w.pixel;
      end
      line_end = col_pos >= img_w - 1;
      col_end = line_end || col_in >= blk_w - 1;
      last_line = row_pos >= img_h - 1;
      row_end = last_line || row_in >= blk_h - 1;
      if (col_end && row_end) begin
        area = (64'(col_in) + 1) * (64'(row_in) + 1);
        bound = 64'((255 * pct) / 100) * area;
        grow = int'(top) - int'(trow);
        t.grid_row = ROW_W'(grow);
        t.grid_col = tcol;
        t.occupied = in_col && ({32'b0, sums[tcol[3:0]]} > bound);
        t.out_of_grid = (grow < 0) || !in_col;
        t.last_of_frame = line_end && last_line;
        tile_queue.push_back(t);
      end
      if (line_end) begin
        col_pos = '0;
        col_in = '0;
        tcol = '0;
        if (last_line) begin
          row_pos = '0;
          row_in = '0;
          trow = '0;
        end else begin
          row_pos = row_pos + 1'b1;
          if (row_end) begin
            row_in = '0;
            trow = trow + 1'b1;
          end else begin
            row_in = row_in + 1'b1;
          end
        end
      end else begin
        col_pos = col_pos + 1'b1;
        if (col_end) begin
          col_in = '0;
          tcol = tcol + 1'b1;
        end else begin
          col_in = col_in + 1'b1;
        end
      end
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_tile(out_t got);
      out_t want;
      if (tile_queue.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $error("tile result with none pending: row %0d col %0d", got.grid_row, got.grid_col);
        return;
      end
      want = tile_queue.pop_front();
      compare_field("grid_row", want.grid_row, got.grid_row);
      compare_field("grid_col", want.grid_col, got.grid_col);
      compare_field("occupied", want.occupied, got.occupied);
      compare_field("out_of_grid", want.out_of_grid, got.out_of_grid);
      compare_field("last_of_frame", want.last_of_frame, got.last_of_frame);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  tile_scoreboard_t sb = new();
  int send_idle = 11;
  int recv_idle = 58;
  int quiet_cycles = 0;

  block_occupancy_grid i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5ns clk = ~clk;

  always @(negedge clk) begin
    out_stall <= $urandom_range(99) < recv_idle;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_tile(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("block_occupancy_grid_test: done, errors");
      $finish;
    end
  end

  task automatic push_word(input in_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_pixel(w);
    @(negedge clk);
  endtask

  task automatic push_pixel(input logic [7:0] pix, input logic fs);
    in_t w;
    w.pixel = pix;
    w.frame_start = fs;
    push_word(w);
  endtask

  // hold the input low until every tile result is out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    logic [31:0] data;
    data = value;
    if ($urandom_range(3) == 0) data[31:SIZE_W] = (32 - SIZE_W)'($urandom);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_pready) break;
    end
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_pixel(pixel_mode_t mode, int unsigned lvl);
    int v;
    case (mode)
      PIX_EXTREME: v = $urandom_range(1) ? 255 : 0;
      PIX_NEAR_LEVEL: v = int'(lvl) + int'($urandom_range(4)) - 2;
      default: v = $urandom_range(255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic directed_checks();
    settle();
    write_register(REG_IMAGE_HEIGHT, 1);
    write_register(REG_BLOCK_WIDTH, 1);
    push_pixel(8'd127, 1'b1);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    // shrink the line under the current column: the edge is taken at once
    settle();
    write_register(REG_IMAGE_WIDTH, 2);
    push_pixel(8'd200, 1'b0);
    // zero sizes act as one, oversized tiles clip, rows run below zero
    settle();
    write_register(REG_IMAGE_WIDTH, 0);
    write_register(REG_IMAGE_HEIGHT, 3);
    write_register(REG_BLOCK_WIDTH, 8191);
    write_register(REG_BLOCK_HEIGHT, 0);
    write_register(REG_TOP_ROW, 1);
    write_register(REG_OCC_PERCENT, 0);
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd255, 1'b0);
    settle();
    write_register(REG_IMAGE_WIDTH, 2);
    write_register(REG_IMAGE_HEIGHT, 2);
    write_register(REG_BLOCK_WIDTH, 4096);
    write_register(REG_BLOCK_HEIGHT, 8191);
    write_register(REG_OCC_PERCENT, 100);
    write_register(REG_TOP_ROW, 63);
    for (int i = 0; i < 4; i++) push_pixel(8'd255, i == 0);
    settle();
    write_register(REG_OCC_PERCENT, 99);
    for (int i = 0; i < 4; i++) push_pixel(8'd253, i == 0);
  endtask

  task automatic random_config(output int unsigned eff_w, output int unsigned eff_h,
                               output int unsigned lvl);
    int unsigned w, h, bw, bh, p, t, r;
    r = $urandom_range(99);
    w = r < 8 ? 0 : (r < 75 ? $urandom_range(12, 1) : $urandom_range(40, 13));
    h = $urandom_range(99) < 8 ? 0 : $urandom_range(8, 1);
    eff_w = w == 0 ? 1 : w;
    eff_h = h == 0 ? 1 : h;
    if (eff_w * eff_h > 160) begin
      h = 160 / eff_w;
      eff_h = h;
    end
    r = $urandom_range(99);
    bw = r < 8 ? 0 : (r < 14 ? ($urandom_range(1) ? 8191 : 4096) : $urandom_range(eff_w + 1, 1));
    r = $urandom_range(99);
    bh = r < 8 ? 0 : (r < 14 ? ($urandom_range(1) ? 8191 : 4096) : $urandom_range(eff_h + 1, 1));
    r = $urandom_range(99);
    p = r < 15 ? 0 : (r < 30 ? 100 : (r < 40 ? 127 : $urandom_range(127)));
    t = $urandom_range(99) < 50 ? $urandom_range(4) : $urandom_range(63);
    lvl = (255 * p) / 100;
    settle();
    write_register(REG_IMAGE_WIDTH, w);
    write_register(REG_IMAGE_HEIGHT, h);
    write_register(REG_BLOCK_WIDTH, bw);
    write_register(REG_BLOCK_HEIGHT, bh);
    write_register(REG_OCC_PERCENT, p);
    write_register(REG_TOP_ROW, t);
  endtask

  task automatic run_random(input int target);
    int unsigned eff_w, eff_h, lvl, len;
    int fed;
    pixel_mode_t mode;
    fed = 0;
    while (fed < target) begin
      random_config(eff_w, eff_h, lvl);
      repeat ($urandom_range(3, 1)) begin
        mode = pixel_mode_t'($urandom_range(2));
        len = eff_w * eff_h;
        if (len > 1 && $urandom_range(9) == 0) len = $urandom_range(len - 1, 1);
        for (int k = 0; k < len && fed < target; k++) begin
          push_pixel(pick_pixel(mode, lvl),
                     k == 0 ? ($urandom_range(7) != 0) : ($urandom_range(49) == 0));
          fed++;
        end
      end
    end
  endtask

  // single-pixel tiles along a full-width line run well past the grid edge
  task automatic run_wide_line();
    settle();
    write_register(REG_IMAGE_WIDTH, 8191);
    write_register(REG_IMAGE_HEIGHT, 1);
    write_register(REG_BLOCK_WIDTH, 1);
    write_register(REG_BLOCK_HEIGHT, 8191);
    write_register(REG_OCC_PERCENT, $urandom_range(100));
    write_register(REG_TOP_ROW, $urandom_range(63));
    for (int k = 0; k < 32; k++) push_pixel(8'($urandom_range(255)), k == 0);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle = 11;
    recv_idle = 58;
    directed_checks();
    run_random(260);
    send_idle = 58;
    recv_idle = 11;
    run_random(260);
    send_idle = 0;
    recv_idle = 0;
    run_random(240);
    run_wide_line();
    settle();
    if (sb.failures == 0) begin
      $display("block_occupancy_grid_test: done, clean");
    end else begin
      $display("block_occupancy_grid_test: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bog_pkg.sv
rtl/core/bog_regs.sv
rtl/core/bog_ctrl.sv
rtl/core/bog_datapath.sv
rtl/core/block_occupancy_grid.sv
bench/block_occupancy_grid_test.sv
